@@ rtl/cst_pkg.sv @@
package cst_pkg;

	localparam int MAX_LEN    = 32;
	localparam int LINE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int LEN_W      = $clog2(MAX_LEN + 1);
	localparam int VAL_W      = 31;
	localparam int FRAC_W     = 6;
	localparam int LINE_OUT_W = 16;

	localparam logic [VAL_W-1:0]  VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [FRAC_W-1:0] FRAC_MAX  = 6'd32;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		KIND_OP    = 3'd0,
		KIND_INT   = 3'd1,
		KIND_FLOAT = 3'd2,
		KIND_IDENT = 3'd3,
		KIND_ERR   = 3'd4,
		KIND_END   = 3'd5
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc;
		logic rep_step;
		logic pend_load;
	} cst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_result;
		logic id_multi;
		logic second;
		logic rep_last;
		logic pend;
	} cst_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic [LINE_OUT_W-1:0] line_out(input logic [LINE_BITS-1:0] l);
		logic [31:0] w;
		w = 32'(l);
		return (w > 32'd65535) ? 16'hFFFF : w[LINE_OUT_W-1:0];
	endfunction

endpackage

@@ rtl/cst_ifs.sv @@
interface cst_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface cst_tok_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        kind;
	logic [7:0]                        symbol;
	logic [cst_pkg::VAL_W-1:0]         number;
	logic [cst_pkg::FRAC_W-1:0]        fraction_digits;
	logic [cst_pkg::LINE_OUT_W-1:0]    line;
	logic                              overflowed;
	logic                              last;

	modport source (output valid, output kind, output symbol, output number,
		output fraction_digits, output line, output overflowed, output last,
		input ready);
	modport sink   (input valid, input kind, input symbol, input number,
		input fraction_digits, input line, input overflowed, input last,
		output ready);
endinterface

@@ rtl/char_stream_tokenizer.sv @@
// Channel   Dir  Fields                                                      Handshake
// chars     in   ch[7:0], end_of_input                                       valid/ready
// tokens    out  kind[2:0], symbol[7:0], number[30:0], fraction_digits[5:0],  valid/ready
//                line[15:0], overflowed, last
//
// One character is taken per cycle while it causes at most one transaction.
// A flushed identifier gives one token per stored letter, followed by the
// ending character's own operator, error or end token when it gives one.
// Results go through one output register; input stalls while it is full and not drained,
// and also for the whole identifier replay and any pending token that follows it.
// arst_n clears the lexer state and the line count; the identifier store is not cleared.
module char_stream_tokenizer (
	input  logic          clk,
	input  logic          arst_n,
	cst_chr_if.sink       chars,
	cst_tok_if.source     tokens
);
	import cst_pkg::*;

	cst_cmd_t  cmd;
	cst_stat_t stat;
	kind_t     kind;

	cst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cst_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ch              (chars.ch),
		.end_of_input    (chars.end_of_input),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.symbol          (tokens.symbol),
		.number          (tokens.number),
		.fraction_digits (tokens.fraction_digits),
		.line            (tokens.line),
		.overflowed      (tokens.overflowed),
		.last            (tokens.last)
	);

	assign tokens.kind = kind;

endmodule

@@ rtl/cst_ctrl.sv @@
module cst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  cst_pkg::cst_stat_t stat,
	output cst_pkg::cst_cmd_t  cmd
);
	import cst_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_REPLAY,
		ST_PEND
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   free;

	// The output register can take a new transaction when empty or being drained.
	assign free      = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_RUN) && free;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.acc       = in_valid && in_ready;
		cmd.rep_step  = (state_q == ST_REPLAY) && free;
		cmd.pend_load = (state_q == ST_PEND) && free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_valid_q && !out_ready;
			unique case (state_q)
				ST_RUN: begin
					if (cmd.acc && stat.has_result) begin
						out_valid_q <= 1'b1;
						if (stat.id_multi) begin
							state_q <= ST_REPLAY;
						end else if (stat.second) begin
							state_q <= ST_PEND;
						end
					end
				end
				ST_REPLAY: begin
					if (cmd.rep_step) begin
						out_valid_q <= 1'b1;
						if (stat.rep_last) begin
							state_q <= stat.pend ? ST_PEND : ST_RUN;
						end
					end
				end
				ST_PEND: begin
					if (cmd.pend_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

@@ rtl/cst_dp.sv @@
module cst_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [7:0]                       ch,
	input  logic                             end_of_input,
	input  cst_pkg::cst_cmd_t                cmd,
	output cst_pkg::cst_stat_t               stat,
	output cst_pkg::kind_t                   kind,
	output logic [7:0]                       symbol,
	output logic [cst_pkg::VAL_W-1:0]        number,
	output logic [cst_pkg::FRAC_W-1:0]       fraction_digits,
	output logic [cst_pkg::LINE_OUT_W-1:0]   line,
	output logic                             overflowed,
	output logic                             last
);
	import cst_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_FLT,
		MODE_ID
	} mode_t;

	mode_t                  mode_q;
	logic [VAL_W-1:0]       acc_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [LEN_W-1:0]       len_q;
	logic [LINE_BITS-1:0]   line_q;
	logic                   ovf_q;
	logic                   pend_q;
	logic [IDX_W-1:0]       idx_q;

	logic [7:0]             store [MAX_LEN];

	kind_t                  kind_q;
	logic [7:0]             symbol_q;
	logic [VAL_W-1:0]       number_q;
	logic [FRAC_W-1:0]      frac_out_q;
	logic [LINE_OUT_W-1:0]  line_out_q;
	logic                   ovf_out_q;
	logic                   last_q;

	kind_t                  pend_kind_q;
	logic [7:0]             pend_sym_q;
	logic [LINE_OUT_W-1:0]  pend_line_q;

	logic                   c_dig, c_let, c_dot, c_ws, c_nl, c_op;
	logic                   cont, flush, idle_path, idle_res, second, id_multi;
	kind_t                  idle_kind, flush_kind;
	logic [3:0]             dval;
	logic [VAL_W+3:0]       prod;
	logic                   prod_big;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;

	always_comb begin
		c_dig = is_digit(ch);
		c_let = is_letter(ch);
		c_dot = (ch == CH_DOT);
		c_ws  = (ch == CH_SPACE) || (ch == CH_TAB);
		c_nl  = (ch == CH_NL);
		c_op  = (ch == CH_STAR) || (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_SLASH);

		// The character extends the open token and causes no result.
		cont = !end_of_input && (((mode_q == MODE_INT) && (c_dig || c_dot)) ||
			((mode_q == MODE_FLT) && c_dig) || ((mode_q == MODE_ID) && c_let));
		flush     = !cont && (mode_q != MODE_IDLE);
		idle_path = !end_of_input && !cont;
		idle_res  = end_of_input || (idle_path && !(c_ws || c_nl || c_dig || c_dot || c_let));
		idle_kind = end_of_input ? KIND_END : (c_op ? KIND_OP : KIND_ERR);
		second    = flush && idle_res;
		id_multi  = flush && (mode_q == MODE_ID) && (len_q > LEN_W'(1));

		flush_kind = (mode_q == MODE_ID) ? KIND_IDENT :
			((mode_q == MODE_FLT) ? KIND_FLOAT : KIND_INT);

		dval     = ch[3:0];
		prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VAL_W + 4)'(dval);
		prod_big = prod > (VAL_W + 4)'(VALUE_MAX);

		wr_en   = !end_of_input && c_let &&
			(idle_path || ((mode_q == MODE_ID) && (len_q < LEN_W'(MAX_LEN))));
		wr_addr = idle_path ? '0 : len_q[IDX_W-1:0];

		stat.has_result = flush || idle_res;
		stat.id_multi   = id_multi;
		stat.second     = second;
		stat.rep_last   = ({1'b0, idx_q} == (len_q - LEN_W'(1)));
		stat.pend       = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			frac_q <= '0;
			len_q  <= '0;
			line_q <= '0;
			ovf_q  <= 1'b0;
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (cmd.acc) begin
				pend_q <= second;
				idx_q  <= IDX_W'(1);
				if (end_of_input) begin
					mode_q <= MODE_IDLE;
					acc_q  <= '0;
					frac_q <= '0;
					ovf_q  <= 1'b0;
				end else if (cont) begin
					priority if (mode_q == MODE_INT && c_dig) begin
						if (prod_big) begin
							acc_q <= VALUE_MAX;
							ovf_q <= 1'b1;
						end else begin
							acc_q <= prod[VAL_W-1:0];
						end
					end else if (mode_q == MODE_INT) begin
						mode_q <= MODE_FLT;
						frac_q <= '0;
					end else if (mode_q == MODE_FLT) begin
						// A fraction digit that does not fit is dropped.
						if (prod_big || (frac_q >= FRAC_MAX)) begin
							ovf_q <= 1'b1;
						end else begin
							acc_q  <= prod[VAL_W-1:0];
							frac_q <= frac_q + FRAC_W'(1);
						end
					end else begin
						if (len_q < LEN_W'(MAX_LEN)) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end else begin
					ovf_q  <= 1'b0;
					frac_q <= '0;
					acc_q  <= '0;
					mode_q <= MODE_IDLE;
					if (c_nl && (line_q != '1)) begin
						line_q <= line_q + LINE_BITS'(1);
					end
					if (c_dig) begin
						mode_q <= MODE_INT;
						acc_q  <= VAL_W'(dval);
					end else if (c_dot) begin
						mode_q <= MODE_FLT;
					end else if (c_let) begin
						mode_q <= MODE_ID;
						len_q  <= LEN_W'(1);
					end
				end
			end else if (cmd.rep_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end else if (cmd.pend_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Identifier store and output payload; the output register is also the store's read register.
	always_ff @(posedge clk) begin
		if (cmd.acc && wr_en) begin
			store[wr_addr] <= ch;
		end
		if (cmd.acc) begin
			pend_kind_q <= idle_kind;
			pend_sym_q  <= end_of_input ? 8'd0 : ch;
			pend_line_q <= line_out(line_q);
			if (flush) begin
				kind_q     <= flush_kind;
				symbol_q   <= (mode_q == MODE_ID) ? store[0] : 8'd0;
				number_q   <= (mode_q == MODE_ID) ? '0 : acc_q;
				frac_out_q <= (mode_q == MODE_FLT) ? frac_q : '0;
				ovf_out_q  <= ovf_q;
				line_out_q <= line_out(line_q);
				last_q     <= !(second || id_multi);
			end else begin
				kind_q     <= idle_kind;
				symbol_q   <= end_of_input ? 8'd0 : ch;
				number_q   <= '0;
				frac_out_q <= '0;
				ovf_out_q  <= 1'b0;
				line_out_q <= line_out(line_q);
				last_q     <= 1'b1;
			end
		end else if (cmd.rep_step) begin
			symbol_q <= store[idx_q];
			last_q   <= stat.rep_last && !pend_q;
		end else if (cmd.pend_load) begin
			kind_q     <= pend_kind_q;
			symbol_q   <= pend_sym_q;
			number_q   <= '0;
			frac_out_q <= '0;
			ovf_out_q  <= 1'b0;
			line_out_q <= pend_line_q;
			last_q     <= 1'b1;
		end
	end

	assign kind            = kind_q;
	assign symbol          = symbol_q;
	assign number          = number_q;
	assign fraction_digits = frac_out_q;
	assign line            = line_out_q;
	assign overflowed      = ovf_out_q;
	assign last            = last_q;

endmodule

@@ rtl/cst_checker.sv @@
module cst_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [2:0]                     kind,
	input logic [7:0]                     symbol,
	input logic [cst_pkg::VAL_W-1:0]      number,
	input logic [cst_pkg::FRAC_W-1:0]     fraction_digits,
	input logic                           overflowed,
	input logic                           last
);
	import cst_pkg::*;

	// A stalled transaction holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(symbol) &&
			$stable(number) && $stable(last))
		else $error("stalled token changed");

	// While a token series is still unfinished no new character is taken.
	a_series: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("character taken during an unfinished token series");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END) |-> last && (number == '0) && (symbol == 8'd0))
		else $error("malformed end token");

	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == KIND_OP) || (kind == KIND_ERR)) |->
			(number == '0) && (fraction_digits == '0) && !overflowed)
		else $error("operator or error token carries a value");

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (chars.ready),
	.out_valid       (tokens.valid),
	.out_ready       (tokens.ready),
	.kind            (tokens.kind),
	.symbol          (tokens.symbol),
	.number          (tokens.number),
	.fraction_digits (tokens.fraction_digits),
	.overflowed      (tokens.overflowed),
	.last            (tokens.last)
);

@@ bench/tb_char_stream_tokenizer.sv @@
module tb_char_stream_tokenizer;
	import cst_pkg::*;

	localparam logic [7:0] CH_0  = "0";
	localparam logic [7:0] CH_9  = "9";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_UZ = "Z";
	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LZ = "z";

	localparam int ITEMS_PER_PHASE = 40;
	localparam int SETTLE_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef enum logic [1:0] {LEX_IDLE, LEX_INT, LEX_FLOAT, LEX_IDENT} lex_mode_t;

	typedef struct {
		kind_t                 kind;
		logic [7:0]            symbol;
		logic [VAL_W-1:0]      number;
		logic [FRAC_W-1:0]     fraction_digits;
		logic [LINE_OUT_W-1:0] line;
		logic                  overflowed;
		logic                  last;
	} token_t;

	class token_scoreboard;
		lex_mode_t         mode;
		logic [VAL_W-1:0]  value;
		logic [FRAC_W-1:0] frac_cnt;
		logic [7:0]        name_buf [MAX_LEN];
		int unsigned       name_len;
		longint unsigned   line_cnt;
		logic              sat;
		token_t            expected_q [$];
		token_t            step_q [$];
		int                errors;

		function new();
			mode = LEX_IDLE;
			value = '0;
			frac_cnt = '0;
			name_len = 0;
			line_cnt = 0;
			sat = 1'b0;
			errors = 0;
		endfunction

		static function bit is_numeral(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		static function bit is_alpha(logic [7:0] c);
			return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_token(kind_t k, logic [7:0] sym, logic [VAL_W-1:0] num,
				logic [FRAC_W-1:0] fr, logic ovf);
			token_t t;
			t.kind = k;
			t.symbol = sym;
			t.number = num;
			t.fraction_digits = fr;
			t.line = (line_cnt > 65535) ? 16'hFFFF : LINE_OUT_W'(line_cnt);
			t.overflowed = ovf;
			t.last = 1'b0;
			step_q.push_back(t);
		endfunction

		function void flush_token();
			case (mode)
				LEX_INT: add_token(KIND_INT, 8'h00, value, '0, sat);
				LEX_FLOAT: add_token(KIND_FLOAT, 8'h00, value, frac_cnt, sat);
				LEX_IDENT: begin
					for (int i = 0; i < name_len; i++)
						add_token(KIND_IDENT, name_buf[i], '0, '0, sat);
				end
				default: begin
				end
			endcase
			mode = LEX_IDLE;
		endfunction

		// Works out the tokens that one accepted character transaction releases.
		function void note_input(logic [7:0] c, logic eoi);
			longint unsigned grown;
			longint unsigned line_top;
			line_top = (64'd1 << LINE_BITS) - 1;
			grown = longint'(value) * 10 + longint'(c) - longint'(CH_0);
			step_q.delete();
			if (eoi) begin
				flush_token();
				add_token(KIND_END, 8'h00, '0, '0, 1'b0);
				sat = 1'b0;
				value = '0;
				frac_cnt = '0;
			end else if (mode == LEX_INT && is_numeral(c)) begin
				if (grown > VALUE_MAX) begin
					value = VALUE_MAX;
					sat = 1'b1;
				end else begin
					value = VAL_W'(grown);
				end
			end else if (mode == LEX_INT && c == CH_DOT) begin
				mode = LEX_FLOAT;
				frac_cnt = '0;
			end else if (mode == LEX_FLOAT && is_numeral(c)) begin
				// A fraction digit that does not fit is dropped, not saturated.
				if (grown > VALUE_MAX || frac_cnt >= FRAC_MAX) begin
					sat = 1'b1;
				end else begin
					value = VAL_W'(grown);
					frac_cnt++;
				end
			end else if (mode == LEX_IDENT && is_alpha(c)) begin
				if (name_len < MAX_LEN) begin
					name_buf[name_len] = c;
					name_len++;
				end else begin
					sat = 1'b1;
				end
			end else begin
				// The character that closes a token is lexed again from idle.
				flush_token();
				sat = 1'b0;
				value = '0;
				frac_cnt = '0;
				if (c == CH_SPACE || c == CH_TAB) begin
				end else if (c == CH_NL) begin
					if (line_cnt < line_top)
						line_cnt++;
				end else if (c == CH_STAR || c == CH_PLUS || c == CH_MINUS || c == CH_SLASH) begin
					add_token(KIND_OP, c, '0, '0, 1'b0);
				end else if (is_numeral(c)) begin
					mode = LEX_INT;
					value = VAL_W'(c - CH_0);
				end else if (c == CH_DOT) begin
					mode = LEX_FLOAT;
				end else if (is_alpha(c)) begin
					mode = LEX_IDENT;
					name_buf[0] = c;
					name_len = 1;
				end else begin
					add_token(KIND_ERR, c, '0, '0, 1'b0);
				end
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i])
				expected_q.push_back(step_q[i]);
		endfunction

		function void compare_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(token_t got);
			token_t want;
			if (expected_q.size() == 0) begin
				$error("token with no expectation: kind %0d symbol %0d number %0d",
					got.kind, got.symbol, got.number);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("symbol", want.symbol, got.symbol);
			compare_field("number", want.number, got.number);
			compare_field("fraction_digits", want.fraction_digits, got.fraction_digits);
			compare_field("line", want.line, got.line);
			compare_field("overflowed", want.overflowed, got.overflowed);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	bit   clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   items_sent;
	int   phase_base;
	int   quiet_cycles;

	token_scoreboard sb = new();

	cst_chr_if chars();
	cst_tok_if tokens();

	char_stream_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		tokens.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		token_t got;
		if (arst_n && tokens.valid && tokens.ready) begin
			got.kind = kind_t'(tokens.kind);
			got.symbol = tokens.symbol;
			got.number = tokens.number;
			got.fraction_digits = tokens.fraction_digits;
			got.line = tokens.line;
			got.overflowed = tokens.overflowed;
			got.last = tokens.last;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars.valid && chars.ready) || (tokens.valid && tokens.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic put_char(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.ch <= c;
		chars.end_of_input <= eoi;
		do
			@(posedge clk);
		while (!chars.ready);
		sb.note_input(c, eoi);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic put_text(input string s);
		foreach (s[i])
			put_char(s[i], 1'b0);
	endtask

	task automatic put_end();
		put_char(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic put_digits(input int n, input bit zeros_only);
		for (int i = 0; i < n; i++)
			put_char(zeros_only ? CH_0 : CH_0 + 8'($urandom_range(9)), 1'b0);
	endtask

	task automatic put_letters(input int n);
		for (int i = 0; i < n; i++)
			put_char(($urandom_range(1) ? CH_LA : CH_UA) + 8'($urandom_range(25)), 1'b0);
	endtask

	function automatic logic [7:0] any_op();
		case ($urandom_range(3))
			0: return CH_STAR;
			1: return CH_PLUS;
			2: return CH_MINUS;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic put_random_token();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			put_digits(($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4),
				1'b0);
		end else if (pick < 35) begin
			if ($urandom_range(3) != 0)
				put_digits($urandom_range(1, 3), 1'b0);
			put_char(CH_DOT, 1'b0);
			case ($urandom_range(9))
				0: put_digits($urandom_range(30, 36), 1'b1);
				1: put_digits($urandom_range(8, 12), 1'b0);
				default: put_digits($urandom_range(0, 4), 1'b0);
			endcase
		end else if (pick < 55) begin
			put_letters(($urandom_range(9) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 8)
				: $urandom_range(1, 6));
		end else if (pick < 67) begin
			put_char(any_op(), 1'b0);
		end else if (pick < 77) begin
			case ($urandom_range(2))
				0: put_char(CH_SPACE, 1'b0);
				1: put_char(CH_TAB, 1'b0);
				default: put_char(CH_NL, 1'b0);
			endcase
		end else if (pick < 82) begin
			put_end();
		end else begin
			put_char(8'($urandom_range(255)), 1'b0);
		end
		if ($urandom_range(1) == 0)
			put_char(($urandom_range(1) == 0) ? CH_SPACE : any_op(), 1'b0);
	endtask

	// Holds the sender off until every expected token has arrived, then lets
	// an identifier replay or a closing transaction finish inside the block.
	task automatic drain_results();
		chars.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.ch = 8'h00;
		chars.end_of_input = 1'b0;
		tokens.ready = 1'b0;
		src_idle_pct = 29;
		snk_idle_pct = 63;
		items_sent = 0;
		phase_base = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_text("+-*/");
		put_text("0 2147483647 2147483648 99999999999\t");
		put_text(".5 12. 3.25 1.2.3\n.\n");
		put_text("1.23456789123 0.");
		put_digits(36, 1'b1);
		put_char(CH_SPACE, 1'b0);
		put_text("x Ab+cd-");
		put_letters(MAX_LEN);
		put_char(CH_SPACE, 1'b0);
		put_letters(MAX_LEN + 8);
		put_char(CH_STAR, 1'b0);
		put_text("09:AZaz[`{@");
		put_char(8'h00, 1'b0);
		put_char(8'h0D, 1'b0);
		put_char(8'h0B, 1'b0);
		put_char(8'h0C, 1'b0);
		put_char(8'h7F, 1'b0);
		put_char(8'h80, 1'b0);
		put_char(8'hFF, 1'b0);
		put_text("abc");
		put_end();
		put_text("42");
		put_end();
		put_text("1.5");
		put_end();
		put_end();

		phase_base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle_pct = 63;
				snk_idle_pct = 29;
			end else if (phase == 2) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			while (items_sent < phase_base + (phase + 1) * ITEMS_PER_PHASE)
				put_random_token();
			drain_results();
		end

		put_text("7+ab");
		put_end();
		drain_results();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
